### rtl/core/bkc_pkg.sv
// ----------------------------------------------------------------------------
// bkc_pkg
// Shared types and constants for the bisecting k-means centroid engine.
// ----------------------------------------------------------------------------
package bkc_pkg;

   localparam int MAX_POINTS_DEF   = 1024;
   localparam int MAX_DIMS_DEF     = 8;
   localparam int MAX_CLUSTERS_DEF = 8;
   localparam int COORD_WIDTH_DEF  = 16;

   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_NUM_POINTS   = 2'd0,
      REG_NUM_DIMS     = 2'd1,
      REG_NUM_CLUSTERS = 2'd2,
      REG_SEED_POINT   = 2'd3
   } reg_idx_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_RUN  = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT,      // clear labels, copy seed into centroid 0
      ST_INIT_W,
      ST_FAR_RD,    // farthest-point scan
      ST_FAR_ACC,
      ST_NEWC_RD,   // copy farthest point (or centroid) into new centroid
      ST_NEWC_W,
      ST_ASN_RD,    // reassign members of split cluster
      ST_ASN_ACC,
      ST_MEAN_RD,   // sum members of both clusters
      ST_MEAN_ACC,
      ST_DIV,       // divide sums by counts
      ST_ERR_RD,    // squared error per cluster
      ST_ERR_ACC,
      ST_PICK,      // choose next cluster
      ST_OUT_RD,
      ST_OUT_W
   } state_type;

   // status from sequencer to top
   typedef struct packed {
      logic busy;
   } seq_status_type;

endpackage

### rtl/core/bkc_ram.sv
// ----------------------------------------------------------------------------
// bkc_ram
// Generic single-port-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module bkc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/bkc_divider.sv
// ----------------------------------------------------------------------------
// bkc_divider
// Radix-2 restoring divider, signed dividend truncated toward zero.
// ----------------------------------------------------------------------------
module bkc_divider #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic                    done,
   output logic signed [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         neg_in = dividend[NUM_W-1];
         quo_in = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         trial = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in    = trial - {1'b0, divisor};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule

### rtl/core/bkc_seq.sv
// ----------------------------------------------------------------------------
// bkc_seq
// Clustering sequencer: walks the point, label and centroid memories.
// ----------------------------------------------------------------------------
module bkc_seq #(
   parameter int MAX_POINTS   = bkc_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS     = bkc_pkg::MAX_DIMS_DEF,
   parameter int MAX_CLUSTERS = bkc_pkg::MAX_CLUSTERS_DEF,
   parameter int COORD_WIDTH  = bkc_pkg::COORD_WIDTH_DEF,
   localparam int PW  = $clog2(MAX_POINTS),
   localparam int NPW = $clog2(MAX_POINTS + 1),
   localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
   localparam int NDW = $clog2(MAX_DIMS + 1),
   localparam int KW  = $clog2(MAX_CLUSTERS),
   localparam int NKW = $clog2(MAX_CLUSTERS + 1),
   localparam int SW  = $clog2(MAX_POINTS * MAX_DIMS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NPW-1:0]                np,
   input  logic [NDW-1:0]                nd,
   input  logic [NKW-1:0]                nk,
   input  logic [PW-1:0]                 seed,
   // point store read port
   output logic [SW-1:0]                 pt_rd_addr,
   input  logic signed [COORD_WIDTH-1:0] pt_rd_data,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [KW-1:0]                 out_cluster,
   output logic [DW-1:0]                 out_dim,
   output logic signed [COORD_WIDTH-1:0] out_value,
   output logic [NPW-1:0]                out_count,
   output logic                          out_empty,
   output logic                          out_last,
   output bkc_pkg::seq_status_type       status
);
   import bkc_pkg::*;

   localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int DIFW   = COORD_WIDTH + 1;
   localparam int SQW    = 2 * DIFW;
   localparam int DSTW   = SQW + DW + 1;
   localparam int ERRW   = DSTW + PW + 1;
   localparam int SUMW   = COORD_WIDTH + PW + 1;

   // label memory
   logic          lb_we;
   logic [PW-1:0] lb_wa, lb_ra;
   logic [KW-1:0] lb_wd, lb_rd;
   bkc_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_label (
      .clock(clock), .wr_en(lb_we), .wr_addr(lb_wa), .wr_data(lb_wd),
      .rd_addr(lb_ra), .rd_data(lb_rd));

   // centroid memory
   logic                          ce_we;
   logic [CAW-1:0]                ce_wa, ce_ra;
   logic signed [COORD_WIDTH-1:0] ce_wd, ce_rd;
   bkc_ram #(.WIDTH(COORD_WIDTH), .DEPTH(CDEPTH)) u_cent (
      .clock(clock), .wr_en(ce_we), .wr_addr(ce_wa), .wr_data(ce_wd),
      .rd_addr(ce_ra), .rd_data(ce_rd));

   // second centroid port: shadow copy so both centroids are read in the same cycle
   logic signed [COORD_WIDTH-1:0] cf_rd;
   logic [CAW-1:0]                cf_ra;
   bkc_ram #(.WIDTH(COORD_WIDTH), .DEPTH(CDEPTH)) u_cent2 (
      .clock(clock), .wr_en(ce_we), .wr_addr(ce_wa), .wr_data(ce_wd),
      .rd_addr(cf_ra), .rd_data(cf_rd));

   state_type state_ff, state_in;

   logic [PW-1:0]   p_ff, p_in;
   logic [DW-1:0]   d_ff, d_in;
   logic [KW-1:0]   c_ff, c_in;      // cluster being split / output cluster
   logic [KW-1:0]   kc_ff, kc_in;    // new cluster
   logic [KW-1:0]   e_ff, e_in;      // error cluster index
   logic            sel_ff, sel_in;  // mean pass: 0 = c, 1 = kc
   logic [DSTW-1:0] da_ff, da_in;    // distance to centroid A
   logic [DSTW-1:0] db_ff, db_in;    // distance to centroid B
   logic [DSTW-1:0] best_ff, best_in;
   logic [PW-1:0]   far_ff, far_in;
   logic            found_ff, found_in;
   logic            skip_ff, skip_in; // current point not a member
   logic [ERRW-1:0] err_ff, err_in;
   logic [ERRW-1:0] berr_ff, berr_in;
   logic [KW-1:0]   next_ff, next_in;
   logic [NPW-1:0]  cnt_ff [MAX_CLUSTERS];
   logic [NPW-1:0]  cnt_in [MAX_CLUSTERS];
   logic [NPW-1:0]  mcnt_ff, mcnt_in;
   logic signed [SUMW-1:0] sum_ff [MAX_DIMS];
   logic signed [SUMW-1:0] sum_in [MAX_DIMS];
   logic            rv_ff, rv_in;
   logic            rd_pend_ff, rd_pend_in;

   logic signed [DIFW-1:0] dif_a, dif_b;
   logic [SQW-1:0]         sq_a, sq_b;
   logic                   last_d, last_p;

   // divider
   logic                    div_start, div_done;
   logic signed [SUMW-1:0]  div_q;
   bkc_divider #(.NUM_W(SUMW), .DEN_W(NPW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(sum_ff[d_ff]), .divisor(mcnt_ff),
      .done(div_done), .quotient(div_q));

   function automatic logic [CAW-1:0] caddr(input logic [KW-1:0] k, input logic [DW-1:0] d);
      caddr = CAW'(k * MAX_DIMS + d);
   endfunction

   // one multiplier per distance; registered accumulate after
   assign dif_a  = DIFW'(pt_rd_data) - DIFW'(ce_rd);
   assign dif_b  = DIFW'(pt_rd_data) - DIFW'(cf_rd);
   assign sq_a   = SQW'(dif_a * dif_a);
   assign sq_b   = SQW'(dif_b * dif_b);
   assign last_d = (NDW'(d_ff) == nd - 1'b1);
   assign last_p = (NPW'(p_ff) == np - 1'b1);

   always_comb begin
      state_in   = state_ff;
      p_in = p_ff; d_in = d_ff; c_in = c_ff; kc_in = kc_ff; e_in = e_ff; sel_in = sel_ff;
      da_in = da_ff; db_in = db_ff; best_in = best_ff; far_in = far_ff; found_in = found_ff;
      skip_in = skip_ff; err_in = err_ff; berr_in = berr_ff; next_in = next_ff;
      cnt_in = cnt_ff; mcnt_in = mcnt_ff; sum_in = sum_ff;
      rv_in = rv_ff; rd_pend_in = 1'b0;
      lb_we = 1'b0; lb_wa = p_ff; lb_wd = '0; lb_ra = p_ff;
      ce_we = 1'b0; ce_wa = '0; ce_wd = '0;
      ce_ra = caddr(c_ff, d_ff); cf_ra = caddr(kc_ff, d_ff);
      pt_rd_addr = SW'(p_ff * nd + d_ff);
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               p_in = '0; d_in = '0; state_in = ST_INIT;
               for (int k = 0; k < MAX_CLUSTERS; k++) cnt_in[k] = '0;
               cnt_in[0] = np;
               c_in = '0; kc_in = KW'(1);
            end
         end
         ST_INIT: begin
            // clear a label and read seed coordinate (while d < nd)
            lb_we = 1'b1; lb_wd = '0;
            pt_rd_addr = SW'(seed * nd + d_ff);
            state_in = ST_INIT_W;
         end
         ST_INIT_W: begin
            if (NDW'(d_ff) < nd) begin
               ce_we = 1'b1; ce_wa = caddr('0, d_ff); ce_wd = pt_rd_data;
            end
            if (NDW'(d_ff) < NDW'(MAX_DIMS - 1)) d_in = d_ff + 1'b1;
            if (last_p) begin
               if (NDW'(d_ff) >= nd - 1'b1) begin
                  d_in = '0; p_in = '0;
                  if (NKW'(kc_ff) < nk && NKW'(1) < nk) begin
                     state_in = ST_FAR_RD; best_in = '0; found_in = 1'b0;
                  end else begin
                     c_in = '0; state_in = ST_OUT_RD;
                  end
               end else state_in = ST_INIT;
            end else begin
               p_in = p_ff + 1'b1; state_in = ST_INIT;
            end
         end
         // farthest point of cluster c
         ST_FAR_RD: begin
            da_in = '0; state_in = ST_FAR_ACC; d_in = '0; rd_pend_in = 1'b1;
         end
         ST_FAR_ACC: begin
            if (rd_pend_ff) begin
               skip_in = (lb_rd != c_ff);
            end else begin
               da_in = da_ff + DSTW'(sq_a);
               if (last_d) begin
                  if (!skip_ff && (da_ff + DSTW'(sq_a)) >= best_ff) begin
                     best_in = da_ff + DSTW'(sq_a); far_in = p_ff; found_in = 1'b1;
                  end
                  d_in = '0;
                  if (last_p) begin
                     p_in = '0; state_in = ST_NEWC_RD;
                  end else begin
                     p_in = p_ff + 1'b1; state_in = ST_FAR_RD;
                  end
               end else d_in = d_ff + 1'b1;
            end
            // address for next cycle
            pt_rd_addr = SW'(p_ff * nd + (rd_pend_ff ? d_ff : DW'(d_ff + 1'b1)));
            ce_ra = caddr(c_ff, rd_pend_ff ? d_ff : DW'(d_ff + 1'b1));
         end
         ST_NEWC_RD: begin
            pt_rd_addr = SW'(far_ff * nd + d_ff);
            state_in = ST_NEWC_W;
         end
         ST_NEWC_W: begin
            ce_we = 1'b1; ce_wa = caddr(kc_ff, d_ff);
            ce_wd = found_ff ? pt_rd_data : ce_rd;
            if (last_d) begin
               d_in = '0; p_in = '0; state_in = ST_ASN_RD;
            end else begin
               d_in = d_ff + 1'b1; state_in = ST_NEWC_RD;
            end
         end
         ST_ASN_RD: begin
            da_in = '0; db_in = '0; d_in = '0; rd_pend_in = 1'b1; state_in = ST_ASN_ACC;
         end
         ST_ASN_ACC: begin
            if (rd_pend_ff) begin
               skip_in = (lb_rd != c_ff);
            end else begin
               da_in = da_ff + DSTW'(sq_a);
               db_in = db_ff + DSTW'(sq_b);
               if (last_d) begin
                  if (!skip_ff && (db_ff + DSTW'(sq_b)) <= (da_ff + DSTW'(sq_a))) begin
                     lb_we = 1'b1; lb_wd = kc_ff;
                  end
                  d_in = '0;
                  if (last_p) begin
                     p_in = '0; sel_in = 1'b0; state_in = ST_MEAN_RD;
                  end else begin
                     p_in = p_ff + 1'b1; state_in = ST_ASN_RD;
                  end
               end else d_in = d_ff + 1'b1;
            end
            pt_rd_addr = SW'(p_ff * nd + (rd_pend_ff ? d_ff : DW'(d_ff + 1'b1)));
            ce_ra = caddr(c_ff, rd_pend_ff ? d_ff : DW'(d_ff + 1'b1));
            cf_ra = caddr(kc_ff, rd_pend_ff ? d_ff : DW'(d_ff + 1'b1));
         end
         ST_MEAN_RD: begin
            if (p_ff == '0) begin
               for (int k = 0; k < MAX_DIMS; k++) sum_in[k] = '0;
               mcnt_in = '0;
            end
            d_in = '0; rd_pend_in = 1'b1; state_in = ST_MEAN_ACC;
         end
         ST_MEAN_ACC: begin
            if (rd_pend_ff) begin
               skip_in = (lb_rd != (sel_ff ? kc_ff : c_ff));
               if (lb_rd == (sel_ff ? kc_ff : c_ff)) mcnt_in = mcnt_ff + 1'b1;
            end else begin
               if (!skip_ff) sum_in[d_ff] = sum_ff[d_ff] + SUMW'(pt_rd_data);
               if (last_d) begin
                  d_in = '0;
                  if (last_p) begin
                     p_in = '0; state_in = ST_DIV;
                     if (sel_ff) cnt_in[kc_ff] = mcnt_ff; else cnt_in[c_ff] = mcnt_ff;
                  end else begin
                     p_in = p_ff + 1'b1; state_in = ST_MEAN_RD;
                  end
               end else d_in = d_ff + 1'b1;
            end
            pt_rd_addr = SW'(p_ff * nd + (rd_pend_ff ? d_ff : DW'(d_ff + 1'b1)));
         end
         ST_DIV: begin
            // one divide per dimension; rd_pend marks a divide in flight
            rd_pend_in = rd_pend_ff;
            if (mcnt_ff == '0) begin
               rd_pend_in = 1'b0;
               d_in = '0;
               if (sel_ff) begin
                  state_in = ST_ERR_RD; e_in = '0; p_in = '0;
               end else begin
                  sel_in = 1'b1; state_in = ST_MEAN_RD;
               end
            end else if (!rd_pend_ff) begin
               div_start = 1'b1; rd_pend_in = 1'b1;
            end else if (div_done) begin
               rd_pend_in = 1'b0;
               ce_we = 1'b1; ce_wa = caddr(sel_ff ? kc_ff : c_ff, d_ff);
               ce_wd = COORD_WIDTH'(div_q);
               if (last_d) begin
                  d_in = '0;
                  if (sel_ff) begin
                     state_in = ST_ERR_RD; e_in = '0; p_in = '0;
                  end else begin
                     sel_in = 1'b1; state_in = ST_MEAN_RD;
                  end
               end else d_in = d_ff + 1'b1;
            end
         end
         // error of cluster e: one pass per cluster 0..kc
         ST_ERR_RD: begin
            if (p_ff == '0) err_in = '0;
            da_in = '0; d_in = '0; rd_pend_in = 1'b1; state_in = ST_ERR_ACC;
         end
         ST_ERR_ACC: begin
            if (rd_pend_ff) begin
               skip_in = (lb_rd != e_ff);
            end else begin
               da_in = da_ff + DSTW'(sq_a);
               if (last_d) begin
                  if (!skip_ff) err_in = err_ff + ERRW'(da_ff + DSTW'(sq_a));
                  d_in = '0;
                  if (last_p) begin
                     p_in = '0; state_in = ST_PICK;
                  end else begin
                     p_in = p_ff + 1'b1; state_in = ST_ERR_RD;
                  end
               end else d_in = d_ff + 1'b1;
            end
            pt_rd_addr = SW'(p_ff * nd + (rd_pend_ff ? d_ff : DW'(d_ff + 1'b1)));
            ce_ra = caddr(e_ff, rd_pend_ff ? d_ff : DW'(d_ff + 1'b1));
         end
         ST_PICK: begin
            if (e_ff == '0 || err_ff >= berr_ff) begin
               berr_in = err_ff; next_in = e_ff;
            end
            if (e_ff == kc_ff) begin
               c_in = (e_ff == '0 || err_ff >= berr_ff) ? e_ff : next_ff;
               if (NKW'(kc_ff) + 1'b1 < nk) begin
                  kc_in = kc_ff + 1'b1; state_in = ST_FAR_RD;
                  best_in = '0; found_in = 1'b0;
               end else begin
                  c_in = '0; state_in = ST_OUT_RD;
               end
            end else begin
               e_in = e_ff + 1'b1; state_in = ST_ERR_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_W;
         end
         ST_OUT_W: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
            end else if (!rsp_stall) begin
               rv_in = 1'b0;
               if (last_d && NKW'(c_ff) == nk - 1'b1) begin
                  d_in = '0; state_in = ST_IDLE;
               end else if (last_d) begin
                  d_in = '0; c_in = c_ff + 1'b1; state_in = ST_OUT_RD;
               end else begin
                  d_in = d_ff + 1'b1; state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // label read follows the point pointer
      if (state_ff == ST_FAR_RD || state_ff == ST_ASN_RD || state_ff == ST_MEAN_RD ||
          state_ff == ST_ERR_RD) begin
         pt_rd_addr = SW'(p_ff * nd);
         ce_ra = caddr(state_ff == ST_ERR_RD ? e_ff : c_ff, '0);
         cf_ra = caddr(kc_ff, '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         p_ff <= '0; d_ff <= '0; c_ff <= '0; kc_ff <= '0;
         rd_pend_ff <= 1'b0;
         for (int k = 0; k < MAX_CLUSTERS; k++) cnt_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         p_ff <= p_in; d_ff <= d_in; c_ff <= c_in; kc_ff <= kc_in;
         rd_pend_ff <= rd_pend_in;
         cnt_ff <= cnt_in;
      end
      e_ff <= e_in; sel_ff <= sel_in; da_ff <= da_in; db_ff <= db_in;
      best_ff <= best_in; far_ff <= far_in; found_ff <= found_in; skip_ff <= skip_in;
      err_ff <= err_in; berr_ff <= berr_in; next_ff <= next_in;
      mcnt_ff <= mcnt_in; sum_ff <= sum_in;
   end

   assign rsp_valid   = rv_ff;
   assign out_cluster = c_ff;
   assign out_dim     = d_ff;
   assign out_value   = ce_rd;
   assign out_count   = cnt_ff[c_ff];
   assign out_empty   = (cnt_ff[c_ff] == '0);
   assign out_last    = last_d && (NKW'(c_ff) == nk - 1'b1);
   assign status.busy = (state_ff != ST_IDLE);
endmodule

### rtl/core/bisecting_kmeans_centroids_top.sv
// ----------------------------------------------------------------------------
// bisecting_kmeans_centroids_top
// Bisecting k-means over stored Q8.8 points, emits centroid coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: operation 0 loads one coordinate (point-major) into the point
//   store; one load item is taken every cycle while idle. operation 1 runs the
//   clustering and then emits nk*nd rsp items, cluster-major, last on the final.
//   A run walks the point store once per pass: one seed pass, then per split a
//   farthest-point pass, an assign pass, two mean passes and one error pass per
//   existing cluster, plus a bit-serial divide per coordinate of the two updated
//   centroids. Pass length is set by the single read port of the point memory.
//   req_stall stays high until the last rsp item is taken. Each rsp item is
//   held while rsp_stall is high; once taken, rsp_valid drops while the
//   sequencer steps through ST_OUT_RD and ST_OUT_W, then the next one is
//   offered. Reset clears the registers, the load position and the counts; the
//   point memory is not cleared. Registers are written over the APB-style port.
// ----------------------------------------------------------------------------
module bisecting_kmeans_centroids_top #(
   parameter int MAX_POINTS   = bkc_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS     = bkc_pkg::MAX_DIMS_DEF,
   parameter int MAX_CLUSTERS = bkc_pkg::MAX_CLUSTERS_DEF,
   parameter int COORD_WIDTH  = bkc_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic signed [COORD_WIDTH-1:0] req_coord_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_cluster_index,
   output logic [2:0]                    rsp_dim_index,
   output logic signed [COORD_WIDTH-1:0] rsp_centroid_value,
   output logic [10:0]                   rsp_member_count,
   output logic                          rsp_empty_flag,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bkc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bkc_pkg::*;

   localparam int PW  = $clog2(MAX_POINTS);
   localparam int NPW = $clog2(MAX_POINTS + 1);
   localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int NDW = $clog2(MAX_DIMS + 1);
   localparam int KW  = $clog2(MAX_CLUSTERS);
   localparam int NKW = $clog2(MAX_CLUSTERS + 1);
   localparam int STORE = MAX_POINTS * MAX_DIMS;
   localparam int SW  = $clog2(STORE);
   localparam int LPW = $clog2(STORE + 1);

   logic [10:0] num_points_ff;
   logic [3:0]  num_dims_ff, num_clusters_ff;
   logic [9:0]  seed_point_ff;
   logic [LPW-1:0] load_pos_ff;
   logic        wr;
   reg_idx_type ridx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign ridx   = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff   <= 11'd1024;
         num_dims_ff     <= 4'd8;
         num_clusters_ff <= 4'd8;
         seed_point_ff   <= '0;
      end else if (wr && paddr[1:0] == 2'b00) begin
         unique case (ridx)
            REG_NUM_POINTS:   num_points_ff   <= pwdata[10:0];
            REG_NUM_DIMS:     num_dims_ff     <= pwdata[3:0];
            REG_NUM_CLUSTERS: num_clusters_ff <= pwdata[3:0];
            REG_SEED_POINT:   seed_point_ff   <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_NUM_POINTS:   prdata = 32'(num_points_ff);
         REG_NUM_DIMS:     prdata = 32'(num_dims_ff);
         REG_NUM_CLUSTERS: prdata = 32'(num_clusters_ff);
         REG_SEED_POINT:   prdata = 32'(seed_point_ff);
         default:          prdata = '0;
      endcase
   end

   // clamped run settings
   logic [NPW-1:0] np;
   logic [NDW-1:0] nd;
   logic [NKW-1:0] nk;
   logic [PW-1:0]  seed;
   always_comb begin
      np = (num_points_ff == '0) ? NPW'(1) :
           (32'(num_points_ff) > MAX_POINTS) ? NPW'(MAX_POINTS) : NPW'(num_points_ff);
      nd = (num_dims_ff == '0) ? NDW'(1) :
           (32'(num_dims_ff) > MAX_DIMS) ? NDW'(MAX_DIMS) : NDW'(num_dims_ff);
      nk = (num_clusters_ff == '0) ? NKW'(1) :
           (32'(num_clusters_ff) > MAX_CLUSTERS) ? NKW'(MAX_CLUSTERS) : NKW'(num_clusters_ff);
      seed = (32'(seed_point_ff) < 32'(np)) ? PW'(seed_point_ff) : PW'(np - 1'b1);
   end

   seq_status_type st;
   logic           acc, load_we, run_start;
   logic [SW-1:0]  pt_ra;
   logic signed [COORD_WIDTH-1:0] pt_rd;

   assign req_stall = st.busy;
   assign acc       = req_valid && !req_stall;
   assign load_we   = acc && req_operation == OP_LOAD && load_pos_ff < LPW'(STORE);
   assign run_start = acc && req_operation == OP_RUN;

   always_ff @(posedge clock) begin
      if (reset) load_pos_ff <= '0;
      else if (load_we) load_pos_ff <= load_pos_ff + 1'b1;
   end

   bkc_ram #(.WIDTH(COORD_WIDTH), .DEPTH(STORE)) u_points (
      .clock(clock), .wr_en(load_we), .wr_addr(SW'(load_pos_ff)), .wr_data(req_coord_value),
      .rd_addr(pt_ra), .rd_data(pt_rd));

   logic [KW-1:0]  oc;
   logic [DW-1:0]  od;
   logic [NPW-1:0] ocnt;

   bkc_seq #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS), .MAX_CLUSTERS(MAX_CLUSTERS),
             .COORD_WIDTH(COORD_WIDTH)) u_seq (
      .clock(clock), .reset(reset), .start(run_start),
      .np(np), .nd(nd), .nk(nk), .seed(seed),
      .pt_rd_addr(pt_ra), .pt_rd_data(pt_rd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .out_cluster(oc), .out_dim(od), .out_value(rsp_centroid_value),
      .out_count(ocnt), .out_empty(rsp_empty_flag), .out_last(rsp_last),
      .status(st));

   assign rsp_cluster_index = 3'(oc);
   assign rsp_dim_index     = 3'(od);
   assign rsp_member_count  = 11'(ocnt);
endmodule

### rtl/core/bkc_checker.sv
// ----------------------------------------------------------------------------
// bkc_checker
// Port-level checks on the centroid engine.
// ----------------------------------------------------------------------------
module bkc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_last,
   input logic        rsp_empty_flag,
   input logic [10:0] rsp_member_count,
   input logic [15:0] rsp_centroid_value
);
   // output item holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_centroid_value))
      else $error("rsp item changed under stall");
   // no result while accepting requests
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("rsp while idle");
   // empty flag matches count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_flag == (rsp_member_count == 11'd0)))
      else $error("empty flag mismatch");
   // after the last item is taken the block becomes idle
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !req_stall)
      else $error("not idle after last");
endmodule

bind bisecting_kmeans_centroids_top bkc_checker u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_last(rsp_last),
   .rsp_empty_flag(rsp_empty_flag), .rsp_member_count(rsp_member_count),
   .rsp_centroid_value(rsp_centroid_value));

### tb/bisecting_kmeans_centroids_checker.sv
// ----------------------------------------------------------------------------
// bisecting_kmeans_centroids_checker
// Watches the req, rsp and register ports, predicts the centroid words of each
// run item with its own bisecting k-means model and compares them in order.
// ----------------------------------------------------------------------------
module bisecting_kmeans_centroids_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_operation,
   input  logic signed [15:0]             req_coord_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [2:0]                     rsp_cluster_index,
   input  logic [2:0]                     rsp_dim_index,
   input  logic signed [15:0]             rsp_centroid_value,
   input  logic [10:0]                    rsp_member_count,
   input  logic                           rsp_empty_flag,
   input  logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [bkc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output int                             mismatches,
   output int                             pending_words,
   output int                             words_checked,
   output int                             runs_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import bkc_pkg::*;

   localparam int STORE_DEPTH = MAX_POINTS_DEF * MAX_DIMS_DEF;

   typedef struct {
      logic [2:0]  cluster;
      logic [2:0]  dim;
      logic [15:0] value;
      logic [10:0] count;
      logic        empty;
      logic        last;
   } centroid_word_type;

   centroid_word_type expected_words[$];

   logic signed [15:0] point_mem[STORE_DEPTH];
   int unsigned        fill_pos;
   logic [10:0]        cfg_points;
   logic [3:0]         cfg_dims;
   logic [3:0]         cfg_clusters;
   logic [9:0]         cfg_seed;

   int unsigned        label[MAX_POINTS_DEF];
   longint             centroid[MAX_CLUSTERS_DEF][MAX_DIMS_DEF];
   longint unsigned    members[MAX_CLUSTERS_DEF];
   longint unsigned    sq_error[MAX_CLUSTERS_DEF];
   int                 cur_dims;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic longint unsigned sq_dist(input int p, input int c);
      longint unsigned s;
      longint x;
      s = 0;
      for (int d = 0; d < cur_dims; d++) begin
         x = longint'(point_mem[p*cur_dims+d]) - centroid[c][d];
         s += longint'(x * x);
      end
      return s;
   endfunction

   function automatic void update_mean(input int c, input int np);
      longint sum[MAX_DIMS_DEF];
      longint n;
      n = 0;
      for (int d = 0; d < MAX_DIMS_DEF; d++) sum[d] = 0;
      for (int p = 0; p < np; p++) begin
         if (label[p] == c) begin
            n++;
            for (int d = 0; d < cur_dims; d++) sum[d] += point_mem[p*cur_dims+d];
         end
      end
      members[c] = n;
      if (n != 0)
         for (int d = 0; d < cur_dims; d++) centroid[c][d] = sum[d] / n;
   endfunction

   function automatic void predict_centroids();
      int np, nk, seed, c, next, far;
      longint unsigned best, best_err, dd;
      bit found;
      centroid_word_type w;
      np = (cfg_points == 0) ? 1 : (cfg_points > MAX_POINTS_DEF ? MAX_POINTS_DEF : cfg_points);
      cur_dims = (cfg_dims == 0) ? 1 : (cfg_dims > MAX_DIMS_DEF ? MAX_DIMS_DEF : cfg_dims);
      nk = (cfg_clusters == 0) ? 1 :
           (cfg_clusters > MAX_CLUSTERS_DEF ? MAX_CLUSTERS_DEF : cfg_clusters);
      seed = (cfg_seed < np) ? cfg_seed : np - 1;
      for (int p = 0; p < np; p++) label[p] = 0;
      for (int k = 0; k < MAX_CLUSTERS_DEF; k++) begin
         members[k] = 0;
         sq_error[k] = 0;
      end
      members[0] = np;
      for (int d = 0; d < cur_dims; d++) centroid[0][d] = point_mem[seed*cur_dims+d];
      c = 0;
      for (int kc = 1; kc < nk; kc++) begin
         best = 0; far = 0; found = 0; best_err = 0; next = 0;
         // farthest member becomes the new centroid, later point wins ties
         for (int p = 0; p < np; p++) begin
            if (label[p] == c) begin
               dd = sq_dist(p, c);
               if (dd >= best) begin
                  best = dd; far = p; found = 1;
               end
            end
         end
         for (int d = 0; d < cur_dims; d++)
            centroid[kc][d] = found ? longint'(point_mem[far*cur_dims+d]) : centroid[c][d];
         for (int p = 0; p < np; p++)
            if (label[p] == c && sq_dist(p, kc) <= sq_dist(p, c)) label[p] = kc;
         update_mean(c, np);
         update_mean(kc, np);
         for (int i = 0; i <= kc; i++) sq_error[i] = 0;
         for (int p = 0; p < np; p++)
            if (label[p] <= kc) sq_error[label[p]] += sq_dist(p, label[p]);
         for (int i = 0; i <= kc; i++) begin
            if (sq_error[i] >= best_err) begin
               best_err = sq_error[i]; next = i;
            end
         end
         c = next;
      end
      for (int k = 0; k < nk; k++) begin
         for (int d = 0; d < cur_dims; d++) begin
            w.cluster = 3'(k);
            w.dim     = 3'(d);
            w.value   = 16'(centroid[k][d]);
            w.count   = 11'(members[k]);
            w.empty   = (members[k] == 0);
            w.last    = (k == nk - 1) && (d == cur_dims - 1);
            expected_words.push_back(w);
         end
      end
   endfunction

   always @(posedge clock) begin
      centroid_word_type w;
      if (reset) begin
         cfg_points    = 11'(MAX_POINTS_DEF);
         cfg_dims      = 4'(MAX_DIMS_DEF);
         cfg_clusters  = 4'(MAX_CLUSTERS_DEF);
         cfg_seed      = '0;
         fill_pos      = 0;
         expected_words.delete();
         mismatches    = 0;
         words_checked = 0;
         runs_seen     = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[CSR_ADDR_W-1:2]))
               REG_NUM_POINTS:   cfg_points   = pwdata[10:0];
               REG_NUM_DIMS:     cfg_dims     = pwdata[3:0];
               REG_NUM_CLUSTERS: cfg_clusters = pwdata[3:0];
               REG_SEED_POINT:   cfg_seed     = pwdata[9:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               report("unexpected item", 32'(rsp_centroid_value), 32'(0));
            end else begin
               w = expected_words.pop_front();
               if (rsp_cluster_index !== w.cluster)
                  report("cluster_index", 32'(rsp_cluster_index), 32'(w.cluster));
               if (rsp_dim_index !== w.dim)
                  report("dim_index", 32'(rsp_dim_index), 32'(w.dim));
               if (rsp_centroid_value !== w.value)
                  report("centroid_value", 32'(rsp_centroid_value), 32'(w.value));
               if (rsp_member_count !== w.count)
                  report("member_count", 32'(rsp_member_count), 32'(w.count));
               if (rsp_empty_flag !== w.empty)
                  report("empty_flag", 32'(rsp_empty_flag), 32'(w.empty));
               if (rsp_last !== w.last)
                  report("last", 32'(rsp_last), 32'(w.last));
            end
         end
         if (req_valid && !req_stall) begin
            if (op_type'(req_operation) == OP_LOAD) begin
               // store saturates, later loads are dropped
               if (fill_pos < STORE_DEPTH) begin
                  point_mem[fill_pos] = req_coord_value;
                  fill_pos++;
               end
            end else begin
               runs_seen++;
               predict_centroids();
            end
         end
      end
      pending_words = expected_words.size();
   end

endmodule

### tb/bisecting_kmeans_centroids_top_tb.sv
// ----------------------------------------------------------------------------
// bisecting_kmeans_centroids_top_tb
// Drives load and run items plus register writes into the centroid engine with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module bisecting_kmeans_centroids_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bkc_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, req_operation;
   logic signed [15:0] req_coord_value;
   logic rsp_valid, rsp_stall;
   logic [2:0] rsp_cluster_index, rsp_dim_index;
   logic signed [15:0] rsp_centroid_value;
   logic [10:0] rsp_member_count;
   logic rsp_empty_flag, rsp_last;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;

   int mismatches, pending_words, words_checked, runs_seen;
   bit no_idle;
   int hold_requests, hold_served, hold_left;
   int coords_loaded, load_items;

   bisecting_kmeans_centroids_top u_top (.*);

   bisecting_kmeans_centroids_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   // result side: random stall, or a long hold when asked
   initial begin
      rsp_stall = 0;
      hold_served = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 33);
         end
      end
   end

   task automatic send_item(input op_type op, input logic [15:0] value);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 33) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid       <= 1;
      req_operation   <= op;
      req_coord_value <= value;
      do @(posedge clock); while (req_stall);
      if (op == OP_LOAD) begin
         coords_loaded++;
         load_items++;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      wait (pending_words == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= CSR_ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   task automatic configure(input int np, input int nd, input int nk, input int seed);
      drain();
      write_reg(REG_NUM_POINTS, np);
      write_reg(REG_NUM_DIMS, nd);
      write_reg(REG_NUM_CLUSTERS, nk);
      write_reg(REG_SEED_POINT, seed);
   endtask

   initial begin
      logic [15:0] edge_vals[16];
      logic [15:0] prev_val;
      int nd, nd_eff, np_max, nloads;
      edge_vals = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
                    16'h0001, 16'h0100, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0064,
                    16'hFF9C, 16'h7FFF, 16'h8000, 16'h1234};
      reset = 1;
      req_valid = 0; req_operation = 0; req_coord_value = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      no_idle = 0; hold_requests = 0; coords_loaded = 0; load_items = 0;
      repeat (8) @(negedge clock);
      reset <= 0;

      // two identical points: split leaves cluster 0 empty
      configure(2, 1, 3, 0);
      foreach (edge_vals[i]) send_item(OP_LOAD, edge_vals[i]);
      send_item(OP_RUN, 16'($urandom));
      // single point, seed clamped, most clusters
      configure(1, 1, 8, 1023);
      send_item(OP_RUN, 16'($urandom));
      configure(4, 4, 8, 3);
      send_item(OP_RUN, 16'($urandom));
      // zero registers clamp up to one
      configure(0, 0, 0, 0);
      send_item(OP_RUN, 16'($urandom));

      prev_val = 0;
      for (int g = 0; g < 32; g++) begin
         no_idle = (g >= 12 && g < 18);
         if (g == 0 || $urandom_range(99) < 60) begin
            nd = ($urandom_range(9) == 0) ? 15 : $urandom_range(1, 8);
            nd_eff = (nd > 8) ? 8 : nd;
            np_max = coords_loaded / nd_eff;
            if (np_max > 10) np_max = 10;
            configure($urandom_range(1, np_max), nd,
                      ($urandom_range(9) == 0) ? 15 : $urandom_range(1, 8),
                      $urandom_range(0, 12));
         end
         nloads = $urandom_range(0, 16);
         for (int i = 0; i < nloads; i++) begin
            // repeated values make distance ties
            if ($urandom_range(99) >= 20) prev_val = 16'($urandom);
            send_item(OP_LOAD, prev_val);
         end
         if (g == 5) hold_requests++;
         send_item(OP_RUN, 16'($urandom));
         if (g == 5)
            for (int i = 0; i < 6; i++) send_item(OP_LOAD, 16'($urandom));
         if (g == 20) drain();
      end

      // clamped registers over the loaded points
      no_idle = 0;
      while (coords_loaded < 64) send_item(OP_LOAD, 16'($urandom));
      configure(8, 8, 2, 1023);
      send_item(OP_RUN, 16'($urandom));
      configure(7, 15, 15, 1000);
      send_item(OP_RUN, 16'($urandom));

      @(negedge clock);
      req_valid <= 0;
      wait (pending_words == 0);
      repeat (60) @(posedge clock);
      $display("Run covered %0d load items and %0d run items, %0d centroid words compared,",
               load_items, runs_seen, words_checked);
      $display("including empty clusters, clamped registers, ties and a long output hold.");
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
rtl/core/bkc_pkg.sv
rtl/core/bkc_ram.sv
rtl/core/bkc_divider.sv
rtl/core/bkc_seq.sv
rtl/core/bisecting_kmeans_centroids_top.sv
rtl/core/bkc_checker.sv
tb/bisecting_kmeans_centroids_checker.sv
tb/bisecting_kmeans_centroids_top_tb.sv
